FILE: design/lrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_pkg: shared definitions of the LSD radix sort engine
// Key port width and the default sizing of the sort engine.
// ----------------------------------------------------------------------------
package lrs_pkg;

    // Width of a key on both channels
    localparam int KEY_W = 32;

    // Default sizing of the engine
    localparam int LRS_MAX_KEYS   = 64;
    localparam int LRS_DIGIT_BITS = 4;
    localparam int LRS_KEY_BITS   = 32;

endpackage

FILE: design/lsd_radix_sort_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsd_radix_sort_engine_top: LSD radix sort engine
// Collects a set of keys, sorts them with a stable LSD radix sort and
// streams them back in ascending order.
// ----------------------------------------------------------------------------
//  channel | ports                                 | direction | request
//  --------+---------------------------------------+-----------+-----------------
//  input   | s_valid s_ready s_key_in s_last_in    | in        | one key to load
//  result  | m_valid m_ready m_key_out m_last_out  | out       | one sorted key
//
//  Loading accepts one key per cycle while s_valid is high. A request with
//  s_last_in starts the sort: each of ceil(KEY_BITS/DIGIT_BITS) passes runs
//  the single bin RAM read-increment-write unit through clear, count, prefix
//  sum and scatter. Each sorted key is then read, loaded into the output
//  register and held until m_ready takes it. s_ready is low from the last
//  key until the final sorted key is taken. Reset is synchronous on aresetn;
//  no clearing pass is needed.
// ----------------------------------------------------------------------------
module lsd_radix_sort_engine_top
    import lrs_pkg::*;
#(
    parameter int MAX_KEYS   = LRS_MAX_KEYS,
    parameter int DIGIT_BITS = LRS_DIGIT_BITS,
    parameter int KEY_BITS   = LRS_KEY_BITS
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [KEY_W-1:0] s_key_in,
    input  logic             s_last_in,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [KEY_W-1:0] m_key_out,
    output logic             m_last_out
);

    localparam int NB = 1 << DIGIT_BITS;
    localparam int AW = $clog2(MAX_KEYS);
    localparam int NW = $clog2(MAX_KEYS + 1);
    localparam int BW = DIGIT_BITS + 1;
    localparam int IW = (NW > BW) ? NW : BW;
    localparam int SW = $clog2(KEY_BITS + DIGIT_BITS + 1);

    localparam logic [NW-1:0] MAXK    = NW'(MAX_KEYS);
    localparam logic [IW-1:0] NB_CNT  = IW'(NB);
    localparam logic [IW-1:0] NB_LAST = IW'(NB - 1);
    localparam logic [SW-1:0] DSTEP   = SW'(DIGIT_BITS);
    localparam logic [SW-1:0] KLIM    = SW'(KEY_BITS);

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CLEAR,
        ST_COUNT,
        ST_PREFIX,
        ST_SCATTER,
        ST_NEXT,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_WAIT
    } state_t;

    state_t                state_reg;
    logic [IW-1:0]         idx_reg;
    logic [NW-1:0]         count_reg;
    logic [SW-1:0]         shift_reg;
    logic                  src_b_reg;
    logic                  p1_reg;
    logic                  p2_reg;
    logic [DIGIT_BITS-1:0] d2_reg;
    logic [KEY_W-1:0]      key2_reg;
    logic                  fwd_valid_reg;
    logic [DIGIT_BITS-1:0] fwd_addr_reg;
    logic [NW-1:0]         fwd_data_reg;
    logic [NW-1:0]         run_reg;
    logic                  m_valid_reg;
    logic [KEY_W-1:0]      m_key_reg;
    logic                  m_last_reg;

    logic [IW-1:0]         cnt_ext;
    logic [KEY_W-1:0]      rdata_a;
    logic [KEY_W-1:0]      rdata_b;
    logic [KEY_W-1:0]      src_key;
    logic [KEY_W-1:0]      key_shifted;
    logic [SW-1:0]         bits_left;
    logic [DIGIT_BITS-1:0] ones;
    logic [DIGIT_BITS-1:0] digit_mask;
    logic [DIGIT_BITS-1:0] digit1;
    logic [NW-1:0]         bin_rdata;
    logic [NW-1:0]         bin_cur;
    logic [NW-1:0]         bin_inc;
    logic                  bin_we;
    logic [DIGIT_BITS-1:0] bin_waddr;
    logic [NW-1:0]         bin_wdata;
    logic [DIGIT_BITS-1:0] bin_raddr;
    logic                  a_we;
    logic [AW-1:0]         a_waddr;
    logic [KEY_W-1:0]      a_wdata;
    logic                  b_we;
    logic                  load_fire;

    assign cnt_ext   = IW'(count_reg);
    assign load_fire = s_valid && (state_reg == ST_LOAD);

    // source store of the current pass
    assign src_key = src_b_reg ? rdata_b : rdata_a;

    // digit of the current pass, narrowed on a short last digit
    assign key_shifted = src_key >> shift_reg;
    assign bits_left   = KLIM - shift_reg;
    assign ones        = '1;
    assign digit_mask  = (bits_left >= DSTEP) ? ones : ~(ones << bits_left);
    assign digit1      = key_shifted[DIGIT_BITS-1:0] & digit_mask;

    // bin read value, bypassing the write still landing in the RAM
    assign bin_cur = (fwd_valid_reg && (fwd_addr_reg == d2_reg)) ? fwd_data_reg : bin_rdata;
    assign bin_inc = bin_cur + NW'(1);

    // bin RAM port control
    always_comb begin
        bin_we    = 1'b0;
        bin_waddr = d2_reg;
        bin_wdata = bin_inc;
        bin_raddr = digit1;
        unique case (state_reg)
            ST_CLEAR: begin
                bin_we    = 1'b1;
                bin_waddr = idx_reg[DIGIT_BITS-1:0];
                bin_wdata = '0;
            end
            ST_PREFIX: begin
                bin_we    = p1_reg;
                bin_wdata = run_reg;
                bin_raddr = idx_reg[DIGIT_BITS-1:0];
            end
            ST_COUNT, ST_SCATTER: begin
                bin_we = p2_reg;
            end
            default: begin
                bin_we = 1'b0;
            end
        endcase
    end

    // key store ports: load and scatter write, reads follow the index
    assign a_we    = (load_fire && (count_reg < MAXK))
                     || ((state_reg == ST_SCATTER) && p2_reg && src_b_reg);
    assign a_waddr = (state_reg == ST_LOAD) ? count_reg[AW-1:0] : bin_cur[AW-1:0];
    assign a_wdata = (state_reg == ST_LOAD) ? s_key_in : key2_reg;
    assign b_we    = (state_reg == ST_SCATTER) && p2_reg && !src_b_reg;

    lrs_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_KEYS)
    ) u_store_a (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rdata_a)
    );

    lrs_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_KEYS)
    ) u_store_b (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (bin_cur[AW-1:0]),
        .wdata (key2_reg),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rdata_b)
    );

    lrs_ram #(
        .WIDTH (NW),
        .DEPTH (NB)
    ) u_bins (
        .aclk  (aclk),
        .we    (bin_we),
        .waddr (bin_waddr),
        .wdata (bin_wdata),
        .raddr (bin_raddr),
        .rdata (bin_rdata)
    );

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            idx_reg       <= '0;
            count_reg     <= '0;
            shift_reg     <= '0;
            src_b_reg     <= 1'b0;
            p1_reg        <= 1'b0;
            p2_reg        <= 1'b0;
            fwd_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            p2_reg        <= 1'b0;
            fwd_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_LOAD: begin
                    if (s_valid) begin
                        if (count_reg < MAXK) begin
                            count_reg <= count_reg + NW'(1);
                        end
                        if (s_last_in) begin
                            state_reg <= ST_CLEAR;
                            idx_reg   <= '0;
                            shift_reg <= '0;
                            src_b_reg <= 1'b0;
                        end
                    end
                end
                ST_CLEAR: begin
                    idx_reg <= idx_reg + IW'(1);
                    if (idx_reg == NB_LAST) begin
                        state_reg <= ST_COUNT;
                        idx_reg   <= '0;
                    end
                end
                ST_COUNT, ST_SCATTER: begin
                    // stage 1: key read back, bin read issued; stage 2: bin read back, bin write
                    p1_reg        <= (idx_reg < cnt_ext);
                    p2_reg        <= p1_reg;
                    d2_reg        <= digit1;
                    key2_reg      <= src_key;
                    fwd_valid_reg <= p2_reg;
                    fwd_addr_reg  <= d2_reg;
                    fwd_data_reg  <= bin_inc;
                    if (idx_reg < cnt_ext) begin
                        idx_reg <= idx_reg + IW'(1);
                    end
                    if ((idx_reg == cnt_ext) && !p1_reg && !p2_reg) begin
                        idx_reg <= '0;
                        run_reg <= '0;
                        if (state_reg == ST_COUNT) begin
                            state_reg <= ST_PREFIX;
                        end else begin
                            state_reg <= ST_NEXT;
                        end
                    end
                end
                ST_PREFIX: begin
                    // exclusive prefix sum, counts become start offsets
                    p1_reg <= (idx_reg < NB_CNT);
                    d2_reg <= idx_reg[DIGIT_BITS-1:0];
                    if (idx_reg < NB_CNT) begin
                        idx_reg <= idx_reg + IW'(1);
                    end
                    if (p1_reg) begin
                        run_reg <= run_reg + bin_rdata;
                    end
                    if ((idx_reg == NB_CNT) && !p1_reg) begin
                        state_reg <= ST_SCATTER;
                        idx_reg   <= '0;
                    end
                end
                ST_NEXT: begin
                    src_b_reg <= !src_b_reg;
                    idx_reg   <= '0;
                    if ((shift_reg + DSTEP) >= KLIM) begin
                        state_reg <= ST_EMIT_RD;
                    end else begin
                        shift_reg <= shift_reg + DSTEP;
                        state_reg <= ST_CLEAR;
                    end
                end
                ST_EMIT_RD: begin
                    idx_reg   <= idx_reg + IW'(1);
                    state_reg <= ST_EMIT_LD;
                end
                ST_EMIT_LD: begin
                    m_valid_reg <= 1'b1;
                    m_key_reg   <= src_key;
                    m_last_reg  <= (idx_reg == cnt_ext);
                    state_reg   <= ST_EMIT_WAIT;
                end
                ST_EMIT_WAIT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        if (m_last_reg) begin
                            count_reg <= '0;
                            state_reg <= ST_LOAD;
                        end else begin
                            idx_reg   <= idx_reg + IW'(1);
                            state_reg <= ST_EMIT_LD;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign s_ready    = (state_reg == ST_LOAD);
    assign m_valid    = m_valid_reg;
    assign m_key_out  = m_key_reg;
    assign m_last_out = m_last_reg;

`ifndef SYNTHESIS
    // loading and result delivery never overlap
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("input ready while a sorted key is pending");

    // a last key closes the load window
    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last_in) |=> !s_ready)
        else $error("input still ready after the last key");

    // taking the final sorted key reopens loading
    a_reopen: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_out) |=> s_ready)
        else $error("load not reopened after the final key");

    // key count never passes the store depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAXK)
        else $error("key count beyond store depth");
`endif

endmodule

FILE: design/lrs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, returns the old word on a same-cycle write
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

FILE: tb/sorted_key_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_checker: result checker of the LSD radix sort engine
// Watches both channels. Collects each loaded key set, sorts it with its own
// LSD radix sort and compares every sorted key and its last flag, in order,
// with what the engine streams out.
// ----------------------------------------------------------------------------
module sorted_key_checker
    import lrs_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  logic [KEY_W-1:0] s_key_in,
    input  logic             s_last_in,
    input  logic             m_valid,
    input  logic             m_ready,
    input  logic [KEY_W-1:0] m_key_out,
    input  logic             m_last_out,
    output int               pending,
    output int               fail_count
);

    localparam int DIGIT_VALUES = 1 << LRS_DIGIT_BITS;
    localparam int NUM_PASSES = (LRS_KEY_BITS + LRS_DIGIT_BITS - 1) / LRS_DIGIT_BITS;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             last;
    } sorted_key_t;

    // keys of the set being loaded, and sorted keys still owed by the engine
    logic [KEY_W-1:0] held_keys [$];
    sorted_key_t      sorted_keys [$];

    initial begin
        pending    = 0;
        fail_count = 0;
    end

    task automatic report_mismatch(input string what, input logic [KEY_W-1:0] want,
                                   input logic [KEY_W-1:0] got);
        $display("%0t ns sorted_key_checker: %s mismatch, expected %h got %h",
                 $time, what, want, got);
        fail_count++;
    endtask

    // Stable LSD sort of the held set, digit by digit from bit 0 upward
    task automatic radix_sort_held();
        logic [KEY_W-1:0] src_keys [LRS_MAX_KEYS];
        logic [KEY_W-1:0] dst_keys [LRS_MAX_KEYS];
        logic [KEY_W-1:0] digit_mask;
        int               slot_base [DIGIT_VALUES];
        int               n;
        int               shift;
        int               width;
        int               digit;
        int               running;
        int               prev;
        sorted_key_t      item;

        n = held_keys.size();
        for (int j = 0; j < n; j++) src_keys[j] = held_keys[j];

        for (int pass = 0; pass < NUM_PASSES; pass++) begin
            shift = pass * LRS_DIGIT_BITS;
            // top pass may be narrower than a full digit
            width = LRS_KEY_BITS - shift;
            if (width > LRS_DIGIT_BITS) width = LRS_DIGIT_BITS;
            digit_mask = {KEY_W{1'b1}} >> (KEY_W - width);

            foreach (slot_base[b]) slot_base[b] = 0;
            for (int j = 0; j < n; j++) begin
                digit = int'((src_keys[j] >> shift) & digit_mask);
                slot_base[digit]++;
            end
            // counts into exclusive start offsets
            running = 0;
            for (int b = 0; b < DIGIT_VALUES; b++) begin
                prev         = slot_base[b];
                slot_base[b] = running;
                running     += prev;
            end
            for (int j = 0; j < n; j++) begin
                digit = int'((src_keys[j] >> shift) & digit_mask);
                dst_keys[slot_base[digit]] = src_keys[j];
                slot_base[digit]++;
            end
            src_keys = dst_keys;
        end

        for (int j = 0; j < n; j++) begin
            item.key  = src_keys[j];
            item.last = (j == n - 1);
            sorted_keys.push_back(item);
        end
        held_keys.delete();
    endtask

    // Sample both channels at the clock edge
    always @(posedge aclk) begin
        sorted_key_t want;
        if (!aresetn) begin
            held_keys.delete();
            sorted_keys.delete();
        end else begin
            if (s_valid && s_ready) begin
                // store full: extra keys are dropped, last still sorts
                if (held_keys.size() < LRS_MAX_KEYS) held_keys.push_back(s_key_in);
                if (s_last_in) radix_sort_held();
            end
            if (m_valid && m_ready) begin
                if (sorted_keys.size() == 0) begin
                    report_mismatch("unexpected key", '0, m_key_out);
                end else begin
                    want = sorted_keys.pop_front();
                    if (m_key_out !== want.key) report_mismatch("key", want.key, m_key_out);
                    if (m_last_out !== want.last)
                        report_mismatch("last flag", KEY_W'(want.last), KEY_W'(m_last_out));
                end
            end
        end
        pending = sorted_keys.size();
    end

endmodule

FILE: tb/lsd_radix_sort_engine_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsd_radix_sort_engine_top_tb: testbench of the LSD radix sort engine
// Loads directed and random key sets (single keys, extremes, duplicates,
// over-full sets) under random idling on both channels; the sorted output is
// checked by sorted_key_checker.
// ----------------------------------------------------------------------------
module lsd_radix_sort_engine_top_tb
    import lrs_pkg::*;
();

    localparam int TOTAL_KEYS = 230;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic [KEY_W-1:0] s_key_in;
    logic             s_last_in;
    logic             m_valid;
    logic             m_ready;
    logic [KEY_W-1:0] m_key_out;
    logic             m_last_out;

    int pending;
    int fail_count;
    int send_idle;
    int recv_idle;
    int keys_sent;

    lsd_radix_sort_engine_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_key_in  (s_key_in),
        .s_last_in (s_last_in),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_key_out (m_key_out),
        .m_last_out(m_last_out)
    );

    sorted_key_checker sort_chk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_key_in  (s_key_in),
        .s_last_in (s_last_in),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_key_out (m_key_out),
        .m_last_out(m_last_out),
        .pending   (pending),
        .fail_count(fail_count)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // receiver stalls at random
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // run limit
    initial begin
        #2_000_000;
        $display("lsd_radix_sort_engine_top_tb: FAIL");
        $finish;
    end

    // one load request, with a random gap in front of it
    task automatic send_key(input logic [KEY_W-1:0] key, input logic last);
        if ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < send_idle) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_key_in  <= key;
        s_last_in <= last;
        do @(posedge aclk); while (!s_ready);
        keys_sent++;
    endtask

    // key flavors: full range, dense duplicates, one live digit, shared low bits
    function automatic logic [KEY_W-1:0] random_key(input int flavor);
        unique case (flavor)
            0:       return $urandom;
            1:       return $urandom_range(0, 15);
            2:       return $urandom & (32'hF << (4 * $urandom_range(0, 7)));
            default: return {4'($urandom_range(0, 15)), 28'h1234567};
        endcase
    endfunction

    task automatic send_set(input int count, input int flavor);
        for (int j = 0; j < count; j++) send_key(random_key(flavor), j == count - 1);
    endtask

    // receiver-heavy idling, then sender-heavy, then none
    task automatic set_phase();
        if (keys_sent < 90) begin
            send_idle = 24;
            recv_idle = 74;
        end else if (keys_sent < 170) begin
            send_idle = 74;
            recv_idle = 24;
        end else begin
            send_idle = 0;
            recv_idle = 0;
        end
    endtask

    initial begin
        logic [KEY_W-1:0] extremes [11] = '{
            32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h0000_0001,
            32'h7FFF_FFFF, 32'h0000_000F, 32'hF000_0000, 32'h0000_0010,
            32'h0000_0010, 32'hFFFF_FFFE, 32'h0100_0000
        };
        int set_len;

        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_key_in  = '0;
        s_last_in = 1'b0;
        m_ready   = 1'b0;
        keys_sent = 0;
        set_phase();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single-key sets at both ends of the range
        send_key(32'h0000_0000, 1'b1);
        send_key(32'hFFFF_FFFF, 1'b1);
        // extremes with a duplicate
        foreach (extremes[j]) send_key(extremes[j], j == 10);
        // equal low digits, order decided by the top digit only
        send_key(32'h1234_5678, 1'b0);
        send_key(32'h0234_5678, 1'b0);
        send_key(32'h9234_5678, 1'b1);
        // reversed pair
        send_key(32'h0000_0005, 1'b0);
        send_key(32'h0000_0003, 1'b1);

        // over-full set: two keys past capacity, the second carries last
        send_set(LRS_MAX_KEYS + 2, 0);

        // random sets, mostly small, now and then a full store
        while (keys_sent < TOTAL_KEYS) begin
            set_phase();
            set_len = ($urandom_range(0, 7) == 0) ? LRS_MAX_KEYS
                                                  : int'($urandom_range(1, 12));
            if (set_len > TOTAL_KEYS - keys_sent) set_len = TOTAL_KEYS - keys_sent;
            send_set(set_len, int'($urandom_range(0, 3)));
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (fail_count == 0) begin
            $display("lsd_radix_sort_engine_top_tb: PASS");
        end else begin
            $display("lsd_radix_sort_engine_top_tb: FAIL");
        end
        $finish;
    end

endmodule
